// File: rtl/core/mrbc_pkg.sv
package mrbc_pkg;

    localparam int HIDDEN_UNITS_DEF = 30;
    localparam int MAX_FEATURES_DEF = 1024;

    localparam int VALUE_W   = 16;
    localparam int UNIT_W    = 5;
    localparam int COLUMN_W  = 10;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 11;
    localparam int SUM_W     = 48;
    localparam int WIDE_W    = 56;
    localparam int HALF_W    = 24;
    localparam int FRAC_SHIFT = 12;

    localparam int MUL_A_W = VALUE_W;
    localparam int MUL_B_W = HALF_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SUM_W;

    localparam logic [OP_W-1:0] OP_HIDDEN_WEIGHT = 2'd0;
    localparam logic [OP_W-1:0] OP_OUTPUT_WEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_FEATURE       = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCORE_THRESHOLD = 2'd1;

    localparam logic [COUNT_W-1:0] FEATURE_COUNT_RESET = 11'd1024;
    localparam logic signed [VALUE_W-1:0] WEIGHT_ONE = 16'sd4096;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic [UNIT_W-1:0]          unit_index;
        logic [COLUMN_W-1:0]        feature_index;
        logic signed [VALUE_W-1:0]  sample_value;
    } mrbc_item_t;

    typedef struct packed {
        logic                       predicted_class;
        logic signed [SUM_W-1:0]    output_score;
    } mrbc_result_t;

    // Clamps a wide signed value to the 48-bit signed range.
    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-SUM_W:0] top;
        logic signed [SUM_W-1:0] r;
        top = v[WIDE_W-1:SUM_W-1];
        if (top == '0 || top == '1)
        begin
            r = v[SUM_W-1:0];
        end
        else if (v[WIDE_W-1])
        begin
            r = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SUM_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/mlp_relu_binary_classifier_unit.sv
// A feature word is handled by the single multiply-accumulate that walks the hidden units through the
// weight memory. A feature that completes a sample then runs the output layer, four steps of the
// same multiplier per hidden unit, before the result is offered. After reset the weight memory is
// filled with 1.0 while item_ready stays low; configuration writes are taken throughout.
module mlp_relu_binary_classifier_unit #(
    parameter int HIDDEN_UNITS = mrbc_pkg::HIDDEN_UNITS_DEF,
    parameter int MAX_FEATURES = mrbc_pkg::MAX_FEATURES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_ready,
    input  mrbc_pkg::mrbc_item_t                    item_data,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output mrbc_pkg::mrbc_result_t                  result_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mrbc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [mrbc_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import mrbc_pkg::*;

    localparam int UW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int FSW = $clog2(MAX_FEATURES + 1);
    localparam int CW = ((FSW > COUNT_W) ? FSW : COUNT_W) + 1;
    localparam int MEM_DEPTH = HIDDEN_UNITS * (2 ** FW);
    localparam int MEM_AW = $clog2(MEM_DEPTH);
    localparam int LO_W = MUL_P_W - FRAC_SHIFT;
    localparam int TERM_W = MUL_P_W + FRAC_SHIFT + 1;

    localparam logic [UW-1:0] LAST_UNIT = UW'(HIDDEN_UNITS - 1);
    localparam logic [FW-1:0] LAST_COL = FW'(MAX_FEATURES - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ACCUM = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam logic [1:0] PH_LO   = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_TERM = 2'd2;
    localparam logic [1:0] PH_ADD  = 2'd3;

    logic [2:0]                 state_reg, state_next;
    logic [UW-1:0]              clr_unit_reg, clr_unit_next;
    logic [FW-1:0]              clr_col_reg, clr_col_next;
    logic [COUNT_W-1:0]         feature_count_reg, feature_count_next;
    logic signed [SUM_W-1:0]    threshold_reg, threshold_next;
    logic [FSW-1:0]             features_seen_reg, features_seen_next;
    logic [FW-1:0]              col_reg, col_next;
    logic signed [VALUE_W-1:0]  feature_reg, feature_next;
    logic                       complete_reg, complete_next;
    logic                       issue_reg, issue_next;
    logic [UW-1:0]              acc_u_reg, acc_u_next;
    logic                       s1_valid_reg, s1_valid_next;
    logic [UW-1:0]              s1_unit_reg, s1_unit_next;
    logic                       s2_valid_reg, s2_valid_next;
    logic [UW-1:0]              s2_unit_reg, s2_unit_next;
    logic [UW-1:0]              out_u_reg, out_u_next;
    logic [1:0]                 ph_reg, ph_next;
    logic signed [LO_W-1:0]     lo_reg, lo_next;
    logic signed [TERM_W-1:0]   term_reg, term_next;
    logic signed [SUM_W-1:0]    score_reg, score_next;
    logic                       result_valid_reg, result_valid_next;
    mrbc_result_t               result_reg, result_next;

    logic signed [VALUE_W-1:0]  out_weight_reg [HIDDEN_UNITS];
    logic signed [SUM_W-1:0]    hidden_sum_reg [HIDDEN_UNITS];

    logic                       item_accept;
    logic                       cfg_accept;
    logic                       hw_write;
    logic                       ow_write;
    logic                       feat_accept;
    logic [CW-1:0]              count_eff;
    logic [CW-1:0]              seen_plus;
    logic                       complete_now;
    logic                       column_ok;

    logic                       mem_wr_en;
    logic [MEM_AW-1:0]          mem_wr_addr;
    logic signed [VALUE_W-1:0]  mem_wr_data;
    logic                       mem_rd_en;
    logic [MEM_AW-1:0]          mem_rd_addr;
    logic signed [VALUE_W-1:0]  mem_rd_data;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    logic [UW-1:0]              sum_idx;
    logic signed [SUM_W-1:0]    sum_rd;
    logic signed [SUM_W-1:0]    relu_h;
    logic                       sum_we;
    logic signed [SUM_W-1:0]    sum_wdata;

    assign item_ready   = (state_reg == ST_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign cfg_accept   = cfg_valid && cfg_ready;

    assign hw_write = item_accept && (item_data.operation == OP_HIDDEN_WEIGHT)
                      && (32'(item_data.unit_index) < HIDDEN_UNITS)
                      && (32'(item_data.feature_index) < MAX_FEATURES);
    assign ow_write = item_accept && (item_data.operation == OP_OUTPUT_WEIGHT)
                      && (32'(item_data.unit_index) < HIDDEN_UNITS);
    assign feat_accept = item_accept && (item_data.operation == OP_FEATURE);

    always_comb
    begin
        if (feature_count_reg == '0)
        begin
            count_eff = CW'(1);
        end
        else if (CW'(feature_count_reg) > CW'(MAX_FEATURES))
        begin
            count_eff = CW'(MAX_FEATURES);
        end
        else
        begin
            count_eff = CW'(feature_count_reg);
        end
    end

    assign seen_plus    = CW'(features_seen_reg) + CW'(1);
    assign complete_now = (seen_plus >= count_eff);
    assign column_ok    = (CW'(features_seen_reg) < CW'(MAX_FEATURES));

    // Weight memory: filled after reset, written by weight words, read by the hidden pass.
    assign mem_wr_en   = (state_reg == ST_CLEAR) || hw_write;
    assign mem_wr_addr = (state_reg == ST_CLEAR) ? MEM_AW'({clr_unit_reg, clr_col_reg})
                       : MEM_AW'({UW'(item_data.unit_index), FW'(item_data.feature_index)});
    assign mem_wr_data = (state_reg == ST_CLEAR) ? WEIGHT_ONE : item_data.sample_value;
    assign mem_rd_en   = (state_reg == ST_ACCUM) && issue_reg;
    assign mem_rd_addr = MEM_AW'({acc_u_reg, col_reg});

    mrbc_wmem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (MEM_AW)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign sum_idx = (state_reg == ST_ACCUM) ? s2_unit_reg : out_u_reg;
    assign sum_rd  = hidden_sum_reg[sum_idx];
    assign relu_h  = (sum_rd > 0) ? sum_rd : '0;

    always_comb
    begin
        if (state_reg == ST_ACCUM)
        begin
            mul_a = mem_rd_data;
            mul_b = MUL_B_W'(feature_reg);
        end
        else
        begin
            mul_a = out_weight_reg[out_u_reg];
            if (ph_reg == PH_LO)
            begin
                mul_b = {1'b0, relu_h[HALF_W-1:0]};
            end
            else
            begin
                mul_b = {1'b0, relu_h[SUM_W-1:HALF_W]};
            end
        end
    end

    mrbc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_comb
    begin
        sum_we    = 1'b0;
        sum_wdata = sat48(WIDE_W'(sum_rd) + WIDE_W'(mul_p));
        if (state_reg == ST_ACCUM)
        begin
            sum_we = s2_valid_reg;
        end
        else if (state_reg == ST_OUT && ph_reg == PH_ADD)
        begin
            sum_we    = 1'b1;
            sum_wdata = '0;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        clr_unit_next      = clr_unit_reg;
        clr_col_next       = clr_col_reg;
        feature_count_next = feature_count_reg;
        threshold_next     = threshold_reg;
        features_seen_next = features_seen_reg;
        col_next           = col_reg;
        feature_next       = feature_reg;
        complete_next      = complete_reg;
        issue_next         = issue_reg;
        acc_u_next         = acc_u_reg;
        s1_valid_next      = (state_reg == ST_ACCUM) && issue_reg;
        s1_unit_next       = acc_u_reg;
        s2_valid_next      = s1_valid_reg;
        s2_unit_next       = s1_unit_reg;
        out_u_next         = out_u_reg;
        ph_next            = ph_reg;
        lo_next            = lo_reg;
        term_next          = term_reg;
        score_next         = score_reg;
        result_valid_next  = result_valid_reg && !result_ready;
        result_next        = result_reg;

        if (cfg_accept)
        begin
            case (cfg_index)
                CFG_FEATURE_COUNT:   feature_count_next = cfg_data[COUNT_W-1:0];
                CFG_SCORE_THRESHOLD: threshold_next = signed'(cfg_data);
                default:             ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_col_next = clr_col_reg + 1'b1;
                if (clr_col_reg == LAST_COL)
                begin
                    clr_col_next  = '0;
                    clr_unit_next = clr_unit_reg + 1'b1;
                    if (clr_unit_reg == LAST_UNIT)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (feat_accept)
                begin
                    col_next           = FW'(features_seen_reg);
                    feature_next       = item_data.sample_value;
                    complete_next      = complete_now;
                    features_seen_next = complete_now ? '0 : FSW'(seen_plus);
                    out_u_next         = '0;
                    ph_next            = PH_LO;
                    score_next         = '0;
                    if (column_ok)
                    begin
                        state_next = ST_ACCUM;
                        issue_next = 1'b1;
                        acc_u_next = '0;
                    end
                    else if (complete_now)
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_ACCUM:
            begin
                if (issue_reg)
                begin
                    acc_u_next = acc_u_reg + 1'b1;
                    if (acc_u_reg == LAST_UNIT)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (s2_valid_reg && s2_unit_reg == LAST_UNIT)
                begin
                    state_next = complete_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                ph_next = ph_reg + 1'b1;
                case (ph_reg)
                    PH_LO:   ;
                    PH_HI:   lo_next = LO_W'(mul_p >>> FRAC_SHIFT);
                    PH_TERM: term_next = (TERM_W'(mul_p) <<< FRAC_SHIFT) + TERM_W'(lo_reg);
                    PH_ADD:
                    begin
                        score_next = sat48(WIDE_W'(score_reg) + WIDE_W'(term_reg));
                        out_u_next = out_u_reg + 1'b1;
                        if (out_u_reg == LAST_UNIT)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next           = 1'b1;
                    result_next.predicted_class = (score_reg >= threshold_reg);
                    result_next.output_score    = score_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_unit_reg      <= '0;
            clr_col_reg       <= '0;
            feature_count_reg <= FEATURE_COUNT_RESET;
            threshold_reg     <= '0;
            features_seen_reg <= '0;
            complete_reg      <= 1'b0;
            issue_reg         <= 1'b0;
            acc_u_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_u_reg         <= '0;
            ph_reg            <= PH_LO;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            clr_unit_reg      <= clr_unit_next;
            clr_col_reg       <= clr_col_next;
            feature_count_reg <= feature_count_next;
            threshold_reg     <= threshold_next;
            features_seen_reg <= features_seen_next;
            complete_reg      <= complete_next;
            issue_reg         <= issue_next;
            acc_u_reg         <= acc_u_next;
            s1_valid_reg      <= s1_valid_next;
            s2_valid_reg      <= s2_valid_next;
            out_u_reg         <= out_u_next;
            ph_reg            <= ph_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        feature_reg <= feature_next;
        s1_unit_reg <= s1_unit_next;
        s2_unit_reg <= s2_unit_next;
        lo_reg      <= lo_next;
        term_reg    <= term_next;
        score_reg   <= score_next;
        result_reg  <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIDDEN_UNITS; i++)
            begin
                out_weight_reg[i] <= WEIGHT_ONE;
                hidden_sum_reg[i] <= '0;
            end
        end
        else
        begin
            if (ow_write)
            begin
                out_weight_reg[UW'(item_data.unit_index)] <= item_data.sample_value;
            end
            if (sum_we)
            begin
                hidden_sum_reg[sum_idx] <= sum_wdata;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    a_s2_only_in_accum: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (state_reg == ST_ACCUM))
        else $error("hidden pass product outside the accumulation state");

    a_sample_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (feat_accept && complete_now) |=> (features_seen_reg == '0))
        else $error("feature count not cleared at the end of a sample");

    a_last_unit_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && ph_reg == PH_ADD && out_u_reg == LAST_UNIT)
        |=> (state_reg == ST_DONE))
        else $error("output layer did not finish after the last hidden unit");

    a_seen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (CW'(features_seen_reg) < CW'(MAX_FEATURES)))
        else $error("feature counter out of range");

endmodule

// File: rtl/core/mrbc_wmem.sv
module mrbc_wmem #(
    parameter int DEPTH = 2,
    parameter int ADDR_W = 1
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [mrbc_pkg::VALUE_W-1:0] wr_data,
    input  logic                                rd_en,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic signed [mrbc_pkg::VALUE_W-1:0] rd_data
);
    import mrbc_pkg::*;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/mrbc_mul.sv
module mrbc_mul (
    input  logic                                clk,
    input  logic signed [mrbc_pkg::MUL_A_W-1:0] a,
    input  logic signed [mrbc_pkg::MUL_B_W-1:0] b,
    output logic signed [mrbc_pkg::MUL_P_W-1:0] p
);
    import mrbc_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] p_next;

    assign p_next = MUL_P_W'(a) * MUL_P_W'(b);

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule
